// File: rtl/core/ihex_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Intel HEX record parser.
// Used by every module of the parser; depends on nothing else.
package ihex_pkg;

  // One input request: a character of the file or the end-of-stream mark.
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_stream;
  } in_item_t;

  // One result request: a payload byte or a record or stream status.
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] byte_address;
    logic [2:0]  record_kind;
    logic [2:0]  status;
  } out_item_t;

  // Character classes produced by the front end.
  typedef enum logic [2:0] {
    TOK_HEX,
    TOK_BLANK,
    TOK_COLON,
    TOK_OTHER,
    TOK_EOS
  } tok_cls_e;

  typedef struct packed {
    tok_cls_e   cls;
    logic [3:0] nib;
  } token_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_BAD_DIGIT  = 3'd2,
    ST_BAD_TYPE   = 3'd3,
    ST_BAD_LENGTH = 3'd4,
    ST_CHECKSUM   = 3'd5,
    ST_NO_EOF     = 3'd6
  } status_e;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] REC_DATA      = 3'd0;
  localparam logic [2:0] REC_EOF       = 3'd1;
  localparam logic [2:0] REC_EXT_SEG   = 3'd2;
  localparam logic [2:0] REC_START_SEG = 3'd3;
  localparam logic [2:0] REC_EXT_LIN   = 3'd4;
  localparam logic [2:0] REC_START_LIN = 3'd5;
  localparam logic [7:0] REC_TYPE_MAX  = 8'd5;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;

endpackage

// File: rtl/core/ihex_front.sv
`timescale 1ns / 1ps
// Front end of the parser: accepts characters and classifies each one.
// Depends on ihex_pkg.
module ihex_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ihex_pkg::in_item_t in_item_i,
  output logic              tok_valid_o,
  input  logic              tok_ready_i,
  output ihex_pkg::token_t  tok_o
);

  logic [7:0] ch;

  assign ch          = in_item_i.character;
  assign tok_valid_o = in_valid_i;
  assign in_ready_o  = tok_ready_i;

  always_comb begin
    tok_o.nib = 4'h0;
    if (in_item_i.end_of_stream) begin
      tok_o.cls = ihex_pkg::TOK_EOS;
    end else if (ch >= ihex_pkg::CHAR_ZERO && ch <= ihex_pkg::CHAR_NINE) begin
      tok_o.cls = ihex_pkg::TOK_HEX;
      tok_o.nib = ch[3:0];
    end else if ((ch >= ihex_pkg::CHAR_LO_A && ch <= ihex_pkg::CHAR_LO_F) ||
                 (ch >= ihex_pkg::CHAR_UP_A && ch <= ihex_pkg::CHAR_UP_F)) begin
      // Letters a..f sit at low nibbles 1..6 in both cases.
      tok_o.cls = ihex_pkg::TOK_HEX;
      tok_o.nib = ch[3:0] + 4'd9;
    end else if (ch == ihex_pkg::CHAR_COLON) begin
      tok_o.cls = ihex_pkg::TOK_COLON;
    end else if (ch == ihex_pkg::CHAR_SPACE ||
                 (ch >= ihex_pkg::CHAR_TAB && ch <= ihex_pkg::CHAR_CR)) begin
      tok_o.cls = ihex_pkg::TOK_BLANK;
    end else begin
      tok_o.cls = ihex_pkg::TOK_OTHER;
    end
  end

endmodule

// File: rtl/core/ihex_fifo.sv
`timescale 1ns / 1ps
// Small flip-flop queue of classified characters between front and back end.
// Depends on ihex_pkg.
module ihex_fifo #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  ihex_pkg::token_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output ihex_pkg::token_t pop_data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  ihex_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

// File: rtl/core/ihex_back.sv
`timescale 1ns / 1ps
// Back end of the parser: record state machine, running sum and result register.
// Depends on ihex_pkg.
module ihex_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_valid_i,
  output logic                tok_ready_o,
  input  ihex_pkg::token_t    tok_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ihex_pkg::out_item_t out_item_o
);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_COUNT,
    PH_ADDR,
    PH_TYPE,
    PH_DATA,
    PH_CSUM
  } phase_e;

  phase_e              phase_q, phase_d;
  logic                hns_q, hns_d;
  logic [3:0]          pend_q, pend_d;
  logic [7:0]          cnt_q, cnt_d;
  logic [7:0]          len_q, len_d;
  logic [15:0]         addr_q, addr_d;
  logic [2:0]          type_q, type_d;
  logic [7:0]          idx_q, idx_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          ftp_hi_q, ftp_hi_d;
  logic [7:0]          ftp_lo_q, ftp_lo_d;
  logic [15:0]         upper_q, upper_d;
  logic                eof_q, eof_d;
  logic                halted_q, halted_d;
  logic                out_valid_q, out_valid_d;
  ihex_pkg::out_item_t out_q, res;
  logic                out_load, pop;
  logic [7:0]          byte_v, sum_v;
  logic [31:0]         base;

  function automatic logic length_ok(logic [2:0] t, logic [7:0] len);
    logic ok;
    case (t) inside
      ihex_pkg::REC_EOF:                                   ok = (len == 8'd0);
      ihex_pkg::REC_EXT_SEG, ihex_pkg::REC_EXT_LIN:        ok = (len == 8'd2);
      ihex_pkg::REC_START_SEG, ihex_pkg::REC_START_LIN:    ok = (len == 8'd4);
      default:                                             ok = 1'b1;
    endcase
    return ok;
  endfunction

  assign tok_ready_o = !out_valid_q || out_ready_i;
  assign pop         = tok_valid_i && tok_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign byte_v      = {pend_q, tok_i.nib};
  assign sum_v       = sum_q + byte_v;
  assign base        = {upper_q, addr_q};

  always_comb begin
    phase_d  = phase_q;
    hns_d    = hns_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    addr_d   = addr_q;
    type_d   = type_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    ftp_hi_d = ftp_hi_q;
    ftp_lo_d = ftp_lo_q;
    upper_d  = upper_q;
    eof_d    = eof_q;
    halted_d = halted_q;
    res      = '0;
    out_load = 1'b0;

    if (pop) begin
      if (tok_i.cls == ihex_pkg::TOK_EOS) begin
        if (!halted_q) begin
          out_load   = 1'b1;
          res.kind   = ihex_pkg::KIND_STATUS;
          res.status = (phase_q != PH_WAIT) ? ihex_pkg::ST_BAD_DIGIT :
                       (eof_q ? ihex_pkg::ST_OK : ihex_pkg::ST_NO_EOF);
        end
        phase_d  = PH_WAIT;
        halted_d = 1'b0;
        eof_d    = 1'b0;
        upper_d  = '0;
        hns_d    = 1'b0;
        pend_d   = '0;
      end else if (!halted_q) begin
        if (phase_q == PH_WAIT) begin
          if (tok_i.cls == ihex_pkg::TOK_COLON) begin
            phase_d  = PH_COUNT;
            hns_d    = 1'b0;
            pend_d   = '0;
            cnt_d    = '0;
            len_d    = '0;
            addr_d   = '0;
            type_d   = '0;
            idx_d    = '0;
            sum_d    = '0;
            ftp_hi_d = '0;
            ftp_lo_d = '0;
          end else if (tok_i.cls != ihex_pkg::TOK_BLANK) begin
            out_load   = 1'b1;
            halted_d   = 1'b1;
            res.kind   = ihex_pkg::KIND_STATUS;
            res.status = ihex_pkg::ST_BAD_START;
          end
        end else if (tok_i.cls != ihex_pkg::TOK_HEX) begin
          out_load         = 1'b1;
          halted_d         = 1'b1;
          res.kind         = ihex_pkg::KIND_STATUS;
          res.byte_address = base;
          res.record_kind  = (phase_q == PH_DATA || phase_q == PH_CSUM) ? type_q : '0;
          res.status       = ihex_pkg::ST_BAD_DIGIT;
        end else if (!hns_q) begin
          pend_d = tok_i.nib;
          hns_d  = 1'b1;
        end else begin
          hns_d = 1'b0;
          unique case (phase_q)
            PH_COUNT: begin
              len_d   = byte_v;
              sum_d   = byte_v;
              cnt_d   = 8'd2;
              phase_d = PH_ADDR;
            end
            PH_ADDR: begin
              addr_d = {addr_q[7:0], byte_v};
              sum_d  = sum_v;
              cnt_d  = cnt_q - 8'd1;
              if (cnt_q == 8'd1) begin
                phase_d = PH_TYPE;
              end
            end
            PH_TYPE: begin
              sum_d = sum_v;
              if (byte_v > ihex_pkg::REC_TYPE_MAX) begin
                out_load         = 1'b1;
                halted_d         = 1'b1;
                res.kind         = ihex_pkg::KIND_STATUS;
                res.byte_address = base;
                res.status       = ihex_pkg::ST_BAD_TYPE;
              end else begin
                type_d  = byte_v[2:0];
                cnt_d   = len_q;
                idx_d   = '0;
                phase_d = (len_q != 8'd0) ? PH_DATA : PH_CSUM;
              end
            end
            PH_DATA: begin
              sum_d            = sum_v;
              out_load         = 1'b1;
              res.kind         = ihex_pkg::KIND_BYTE;
              res.payload_byte = byte_v;
              res.byte_address = base + {24'd0, idx_q};
              res.record_kind  = type_q;
              res.status       = ihex_pkg::ST_OK;
              if (idx_q == 8'd0) begin
                ftp_hi_d = byte_v;
                ftp_lo_d = '0;
              end else if (idx_q == 8'd1) begin
                ftp_lo_d = byte_v;
              end
              idx_d = idx_q + 8'd1;
              cnt_d = cnt_q - 8'd1;
              if (cnt_q == 8'd1) begin
                phase_d = PH_CSUM;
              end
            end
            PH_CSUM: begin
              out_load         = 1'b1;
              res.kind         = ihex_pkg::KIND_STATUS;
              res.byte_address = base;
              res.record_kind  = type_q;
              if (sum_v != 8'd0) begin
                halted_d   = 1'b1;
                res.status = ihex_pkg::ST_CHECKSUM;
              end else if (!length_ok(type_q, len_q)) begin
                halted_d   = 1'b1;
                res.status = ihex_pkg::ST_BAD_LENGTH;
              end else begin
                res.status = ihex_pkg::ST_OK;
                if (type_q == ihex_pkg::REC_EXT_LIN) begin
                  upper_d = {ftp_hi_q, ftp_lo_q};
                end
                eof_d   = (type_q == ihex_pkg::REC_EOF);
                phase_d = PH_WAIT;
              end
            end
            default: begin
              phase_d = PH_WAIT;
            end
          endcase
        end
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      hns_q       <= 1'b0;
      pend_q      <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      addr_q      <= '0;
      type_q      <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      ftp_hi_q    <= '0;
      ftp_lo_q    <= '0;
      upper_q     <= '0;
      eof_q       <= 1'b0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      hns_q       <= hns_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      addr_q      <= addr_d;
      type_q      <= type_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      ftp_hi_q    <= ftp_hi_d;
      ftp_lo_q    <= ftp_lo_d;
      upper_q     <= upper_d;
      eof_q       <= eof_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        out_q <= res;
      end
    end
  end

  a_data_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q != 8'd0))
    else $error("payload phase with no bytes left");

  a_halted_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !out_load)
    else $error("result produced while halted");

  a_byte_in_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res.kind == ihex_pkg::KIND_BYTE) |-> (phase_q == PH_DATA && hns_q))
    else $error("payload byte outside payload phase");

endmodule

// File: rtl/core/intel_hex_record_parser.sv
`timescale 1ns / 1ps
// Intel HEX record parser, top level. Each accepted character is written into the
// queue, then taken by the back end, which registers any result for out_valid_o.
// Throughput: one character per cycle while the result side does not stall.
// The queue between front and back end holds QueueDepth characters.
// Reset (rst_ni low, asynchronous) empties the queue and result register and
// returns the parser to waiting for a start colon with the upper address cleared.
module intel_hex_record_parser #(
  parameter int QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ihex_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ihex_pkg::out_item_t out_item_o
);

  // Classified character from the front end, before and after the queue.
  logic             front_valid, front_ready;
  ihex_pkg::token_t front_tok;
  logic             back_valid, back_ready;
  ihex_pkg::token_t back_tok;

  // The front end sorts each character into a class (hex digit with its value,
  // whitespace, colon, anything else, or the end-of-stream mark). Every request
  // is taken whenever the queue has room.
  ihex_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .tok_valid_o (front_valid),
    .tok_ready_i (front_ready),
    .tok_o       (front_tok)
  );

  // The queue lets the input keep flowing for a short while when the result
  // side stalls, and keeps the input ready free of the output ready path.
  ihex_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_tok),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_tok)
  );

  // The back end pairs nibbles into bytes, walks the record fields, keeps the
  // running checksum and the upper address, and registers each result. It
  // takes a new character whenever its result register is free or draining.
  ihex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (back_valid),
    .tok_ready_o (back_ready),
    .tok_i       (back_tok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
